[design/xlab_pkg.sv]
// Shared constants, channel tables and word types for the XYZ to L*a*b* converter.
package xlab_pkg;

    // Fixed-point formats
    localparam int IN_FRAC_BITS  = 9;
    localparam int OUT_FRAC_BITS = 6;
    localparam int T_BITS        = 30;
    localparam int F_BITS        = 24;
    localparam int ROOT_SHIFT    = 42;
    localparam int RND_SHIFT     = F_BITS - OUT_FRAC_BITS;

    // Port widths
    localparam int RAW_W    = 16;
    localparam int LIGHT_W  = 13;
    localparam int CHROMA_W = 16;

    // Datapath widths
    localparam int Y_W   = 27;             // cube root bits, one per root stage
    localparam int S_W   = 2 * Y_W;        // running square of the root
    localparam int D_W   = S_W + 4;        // trial increment 12*y^2 + 6*y + 1
    localparam int R_W   = S_W + 7;        // partial remainder
    localparam int N_W   = 3 * Y_W;        // radicand bits consumed by the root pipe
    localparam int U_W   = 40;             // quotient raw*K/ref
    localparam int Q_W   = 24;             // integer part of K/ref
    localparam int REF_W = 17;             // white point in thousandths
    localparam int M_W   = 32;             // reciprocal fraction bits
    localparam int PR_W  = RAW_W + REF_W;
    localparam int PM_W  = RAW_W + M_W;
    localparam int F_W   = Y_W;            // f(t) with F_BITS fraction bits
    localparam int L_W   = 36;
    localparam int A_W   = 38;

    // Pipeline depth
    localparam int QUOT_STAGES = 4;
    localparam int ROOT_STAGES = Y_W;
    localparam int LAB_STAGES  = 5;
    localparam int PIPE_DEPTH  = QUOT_STAGES + ROOT_STAGES + LAB_STAGES;

    // Color science constants
    localparam longint unsigned WHITE_X_MILLI = 64'd95047;
    localparam longint unsigned WHITE_Y_MILLI = 64'd100000;
    localparam longint unsigned WHITE_Z_MILLI = 64'd108883;
    localparam longint unsigned THRESH_MICRO  = 64'd8856;
    localparam longint unsigned SLOPE_MILLI   = 64'd7787;
    localparam longint unsigned THRESH_DEN    = 64'd1000000000;
    localparam longint unsigned CUBE_K        = 64'd1000 << (T_BITS - IN_FRAC_BITS);
    localparam longint unsigned LIN_K         = SLOPE_MILLI << (F_BITS - IN_FRAC_BITS);
    localparam longint unsigned C16           = ((64'd16 << F_BITS) + 64'd58) / 64'd116;
    localparam longint unsigned L_SCALE       = 64'd116;
    localparam longint unsigned L_OFFSET_FIX  = 64'd16 << F_BITS;
    localparam longint unsigned A_SCALE       = 64'd500;
    localparam longint unsigned B_SCALE       = 64'd200;
    localparam int              LIGHT_MAX     = 8191;
    localparam int              CHROMA_MAX    = 32767;
    localparam int              CHROMA_MIN    = -32768;

    // Per-channel constants: threshold on the raw code, and quotient,
    // remainder and reciprocal of K/ref for both branches of f(t)
    typedef struct packed {
        logic [RAW_W-1:0] thresh;
        logic [REF_W-1:0] ref_milli;
        logic [Q_W-1:0]   cube_q;
        logic [REF_W-1:0] cube_r;
        logic [M_W-1:0]   cube_m;
        logic [Q_W-1:0]   lin_q;
        logic [REF_W-1:0] lin_r;
        logic [M_W-1:0]   lin_m;
    } chan_const_t;

    localparam chan_const_t X_CONST = '{
        thresh:    RAW_W'(((THRESH_MICRO * WHITE_X_MILLI) << IN_FRAC_BITS) / THRESH_DEN),
        ref_milli: REF_W'(WHITE_X_MILLI),
        cube_q:    Q_W'(CUBE_K / WHITE_X_MILLI),
        cube_r:    REF_W'(CUBE_K % WHITE_X_MILLI),
        cube_m:    M_W'(((CUBE_K % WHITE_X_MILLI) << M_W) / WHITE_X_MILLI),
        lin_q:     Q_W'(LIN_K / WHITE_X_MILLI),
        lin_r:     REF_W'(LIN_K % WHITE_X_MILLI),
        lin_m:     M_W'(((LIN_K % WHITE_X_MILLI) << M_W) / WHITE_X_MILLI)
    };

    localparam chan_const_t Y_CONST = '{
        thresh:    RAW_W'(((THRESH_MICRO * WHITE_Y_MILLI) << IN_FRAC_BITS) / THRESH_DEN),
        ref_milli: REF_W'(WHITE_Y_MILLI),
        cube_q:    Q_W'(CUBE_K / WHITE_Y_MILLI),
        cube_r:    REF_W'(CUBE_K % WHITE_Y_MILLI),
        cube_m:    M_W'(((CUBE_K % WHITE_Y_MILLI) << M_W) / WHITE_Y_MILLI),
        lin_q:     Q_W'(LIN_K / WHITE_Y_MILLI),
        lin_r:     REF_W'(LIN_K % WHITE_Y_MILLI),
        lin_m:     M_W'(((LIN_K % WHITE_Y_MILLI) << M_W) / WHITE_Y_MILLI)
    };

    localparam chan_const_t Z_CONST = '{
        thresh:    RAW_W'(((THRESH_MICRO * WHITE_Z_MILLI) << IN_FRAC_BITS) / THRESH_DEN),
        ref_milli: REF_W'(WHITE_Z_MILLI),
        cube_q:    Q_W'(CUBE_K / WHITE_Z_MILLI),
        cube_r:    REF_W'(CUBE_K % WHITE_Z_MILLI),
        cube_m:    M_W'(((CUBE_K % WHITE_Z_MILLI) << M_W) / WHITE_Z_MILLI),
        lin_q:     Q_W'(LIN_K / WHITE_Z_MILLI),
        lin_r:     REF_W'(LIN_K % WHITE_Z_MILLI),
        lin_m:     M_W'(((LIN_K % WHITE_Z_MILLI) << M_W) / WHITE_Z_MILLI)
    };

    // Quotient word: branch of f(t) and raw*K/ref
    typedef struct packed {
        logic           branch;   // high: cube-root branch
        logic [U_W-1:0] quot;
    } quot_t;

    // One word of the cube-root pipe
    typedef struct packed {
        quot_t          q;
        logic [Y_W-1:0] y;
        logic [S_W-1:0] s;
        logic [D_W-1:0] d;
        logic [R_W-1:0] r;
    } root_t;

    // Inputs to the L*a*b* stage for one channel
    typedef struct packed {
        quot_t          q;
        logic [Y_W-1:0] root;
    } chan_f_t;

    // Result word
    typedef struct packed {
        logic [LIGHT_W-1:0]         lightness;
        logic signed [CHROMA_W-1:0] red_green;
        logic signed [CHROMA_W-1:0] yellow_blue;
    } result_t;

endpackage

[design/xlab_quot_unit.sv]
// Raw tristimulus code to threshold branch and quotient raw*K/ref, four stages.
module xlab_quot_unit
    import xlab_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [RAW_W-1:0] raw,
    input  chan_const_t      cc,
    output quot_t            quot_out
);

    logic [RAW_W-1:0] raw0_reg;
    logic             br0_reg;
    logic [U_W-1:0]   pq1_reg;
    logic [PR_W-1:0]  pr1_reg;
    logic [RAW_W-1:0] q01_reg;
    logic             br1_reg;
    logic [PR_W-1:0]  qr2_reg;
    logic [U_W-1:0]   base2_reg;
    logic [PR_W-1:0]  pr2_reg;
    logic             br2_reg;
    logic [U_W-1:0]   quot3_reg;
    logic             br3_reg;

    logic [Q_W-1:0]   q_sel;
    logic [REF_W-1:0] r_sel;
    logic [M_W-1:0]   m_sel;
    logic [PM_W-1:0]  pm;
    logic [PR_W-1:0]  rem;
    logic             corr;
    logic [U_W-1:0]   quot3_next;

    // Pick the constant set of the branch and estimate the fractional quotient
    always_comb begin
        q_sel = br0_reg ? cc.cube_q : cc.lin_q;
        r_sel = br0_reg ? cc.cube_r : cc.lin_r;
        m_sel = br0_reg ? cc.cube_m : cc.lin_m;
        pm    = PM_W'(raw0_reg) * PM_W'(m_sel);
    end

    // Correct the estimate by one when the remainder reaches the divisor
    always_comb begin
        rem        = pr2_reg - qr2_reg;
        corr       = rem >= PR_W'(cc.ref_milli);
        quot3_next = base2_reg + U_W'(corr);
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            raw0_reg  <= raw;
            br0_reg   <= raw > cc.thresh;

            pq1_reg   <= U_W'(raw0_reg) * U_W'(q_sel);
            pr1_reg   <= PR_W'(raw0_reg) * PR_W'(r_sel);
            q01_reg   <= pm[PM_W-1:M_W];
            br1_reg   <= br0_reg;

            qr2_reg   <= PR_W'(q01_reg) * PR_W'(cc.ref_milli);
            base2_reg <= pq1_reg + U_W'(q01_reg);
            pr2_reg   <= pr1_reg;
            br2_reg   <= br1_reg;

            quot3_reg <= quot3_next;
            br3_reg   <= br2_reg;
        end
    end

    assign quot_out.branch = br3_reg;
    assign quot_out.quot   = quot3_reg;

endmodule

[design/xlab_root_step.sv]
// One digit stage of the restoring cube root: three radicand bits in, one root bit out.
module xlab_root_step
    import xlab_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  logic [2:0] grp,
    input  root_t      stage_in,
    output root_t      stage_out
);

    root_t          stage_reg;
    root_t          stage_next;
    logic [R_W-1:0] r_in;
    logic           take;
    logic [D_W-1:0] s48;
    logic [D_W-1:0] y12;

    // Compare the remainder with (2y+1)^3 - (2y)^3 and prepare both next increments
    always_comb begin
        r_in = {stage_in.r[R_W-4:0], grp};
        take = r_in >= R_W'(stage_in.d);
        s48  = (D_W'(stage_in.s) << 5) + (D_W'(stage_in.s) << 4);
        y12  = (D_W'(stage_in.y) << 3) + (D_W'(stage_in.y) << 2);

        stage_next.q = stage_in.q;
        stage_next.y = {stage_in.y[Y_W-2:0], take};
        if (take) begin
            stage_next.r = r_in - R_W'(stage_in.d);
            stage_next.s = (stage_in.s << 2) + (S_W'(stage_in.y) << 2) + S_W'(1);
            stage_next.d = s48 + y12 + (y12 << 2) + D_W'(19);
        end else begin
            stage_next.r = r_in;
            stage_next.s = stage_in.s << 2;
            stage_next.d = s48 + y12 + D_W'(1);
        end
    end

    // Hold while stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

[design/xlab_lab_unit.sv]
// f(t) select, L*/a*/b* scaling, rounding and clamping, five stages.
module xlab_lab_unit
    import xlab_pkg::*;
(
    input  logic    aclk,
    input  logic    en,
    input  chan_f_t fx_in,
    input  chan_f_t fy_in,
    input  chan_f_t fz_in,
    output result_t result
);

    localparam logic signed [A_W-1:0] A_SCALE_S = A_W'(A_SCALE);
    localparam logic signed [A_W-1:0] B_SCALE_S = A_W'(B_SCALE);
    localparam logic signed [L_W-1:0] L_HALF    = L_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [A_W-1:0] A_HALF    = A_W'(1) << (RND_SHIFT - 1);
    localparam logic signed [L_W-1:0] L_MAX_S   = L_W'(LIGHT_MAX);
    localparam logic signed [A_W-1:0] CH_MAX_S  = A_W'(CHROMA_MAX);
    localparam logic signed [A_W-1:0] CH_MIN_S  = A_W'(CHROMA_MIN);

    function automatic logic [F_W-1:0] sel_f(input chan_f_t c);
        sel_f = c.q.branch ? c.root : F_W'(c.q.quot) + F_W'(C16);
    endfunction

    logic [F_W-1:0]          fx0_reg, fy0_reg, fz0_reg;
    logic signed [L_W-1:0]   l1_reg, l2_reg, l3_reg;
    logic signed [F_W:0]     dxy1_reg, dyz1_reg;
    logic signed [A_W-1:0]   a2_reg, b2_reg, a3_reg, b3_reg;
    result_t                 result_reg;

    logic signed [L_W-1:0]   l1_next;
    logic signed [F_W:0]     dxy_next, dyz_next;
    logic signed [A_W-1:0]   dxy_ext, dyz_ext;
    logic signed [A_W-1:0]   a2_next, b2_next;
    logic signed [L_W-1:0]   l_bias;
    logic signed [A_W-1:0]   a_bias, b_bias;
    logic signed [L_W-1:0]   l3_next;
    logic signed [A_W-1:0]   a3_next, b3_next;
    result_t                 result_next;

    // Form L before rounding and the f differences
    always_comb begin
        l1_next  = L_W'(fy0_reg) * L_W'(L_SCALE) - L_W'(L_OFFSET_FIX);
        dxy_next = {1'b0, fx0_reg} - {1'b0, fy0_reg};
        dyz_next = {1'b0, fy0_reg} - {1'b0, fz0_reg};
    end

    // Scale the differences
    always_comb begin
        dxy_ext = {{(A_W-F_W-1){dxy1_reg[F_W]}}, dxy1_reg};
        dyz_ext = {{(A_W-F_W-1){dyz1_reg[F_W]}}, dyz1_reg};
        a2_next = dxy_ext * A_SCALE_S;
        b2_next = dyz_ext * B_SCALE_S;
    end

    // Round to nearest, halves away from zero
    always_comb begin
        l_bias  = l2_reg[L_W-1] ? L_HALF - L_W'(1) : L_HALF;
        a_bias  = a2_reg[A_W-1] ? A_HALF - A_W'(1) : A_HALF;
        b_bias  = b2_reg[A_W-1] ? A_HALF - A_W'(1) : A_HALF;
        l3_next = (l2_reg + l_bias) >>> RND_SHIFT;
        a3_next = (a2_reg + a_bias) >>> RND_SHIFT;
        b3_next = (b2_reg + b_bias) >>> RND_SHIFT;
    end

    // Clamp to the output ranges
    always_comb begin
        if (l3_reg < 0) begin
            result_next.lightness = '0;
        end else if (l3_reg > L_MAX_S) begin
            result_next.lightness = LIGHT_W'(LIGHT_MAX);
        end else begin
            result_next.lightness = l3_reg[LIGHT_W-1:0];
        end

        if (a3_reg < CH_MIN_S) begin
            result_next.red_green = CHROMA_W'(CHROMA_MIN);
        end else if (a3_reg > CH_MAX_S) begin
            result_next.red_green = CHROMA_W'(CHROMA_MAX);
        end else begin
            result_next.red_green = a3_reg[CHROMA_W-1:0];
        end

        if (b3_reg < CH_MIN_S) begin
            result_next.yellow_blue = CHROMA_W'(CHROMA_MIN);
        end else if (b3_reg > CH_MAX_S) begin
            result_next.yellow_blue = CHROMA_W'(CHROMA_MAX);
        end else begin
            result_next.yellow_blue = b3_reg[CHROMA_W-1:0];
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            fx0_reg    <= sel_f(fx_in);
            fy0_reg    <= sel_f(fy_in);
            fz0_reg    <= sel_f(fz_in);

            l1_reg     <= l1_next;
            dxy1_reg   <= dxy_next;
            dyz1_reg   <= dyz_next;

            l2_reg     <= l1_reg;
            a2_reg     <= a2_next;
            b2_reg     <= b2_next;

            l3_reg     <= l3_next;
            a3_reg     <= a3_next;
            b3_reg     <= b3_next;

            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[design/xyz_to_cielab_converter_unit.sv]
// XYZ (D65) to CIE L*a*b* converter: top level with pipeline control and output buffer.
//
// Takes one XYZ word per clock and returns one L*a*b* word per clock for as long
// as the result side keeps m_ready high. On its way from acceptance to m_valid,
// each word passes four stages that form the threshold branch and the quotient
// raw*K/ref by a reciprocal multiply with one correction, 27 stages that compute
// the cube root one bit per stage (three radicand bits each), five stages that
// select f(t), scale, round and clamp, and one output register that holds the
// word. A skid register behind the output catches the word that leaves the pipe
// while the output register is stalled; s_ready then drops until the skid
// register drains.
module xyz_to_cielab_converter_unit
    import xlab_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [RAW_W-1:0]           s_x_value,
    input  logic [RAW_W-1:0]           s_y_value,
    input  logic [RAW_W-1:0]           s_z_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [LIGHT_W-1:0]         m_lightness,
    output logic signed [CHROMA_W-1:0] m_red_green,
    output logic signed [CHROMA_W-1:0] m_yellow_blue
);

    localparam chan_const_t CHAN_CONST [3] = '{X_CONST, Y_CONST, Z_CONST};

    logic [PIPE_DEPTH-1:0] valid_pipe_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    result_t               out_reg;
    result_t               skid_reg;
    logic                  en;
    logic                  push;
    logic                  pop;
    logic                  load_out;
    logic                  load_skid;
    logic                  out_from_skid;

    logic [RAW_W-1:0]      raw_in [3];
    quot_t                 quot_w [3];
    root_t                 chain  [3][ROOT_STAGES+1];
    chan_f_t               f_in   [3];
    result_t               lab_result;

    // Whole pipe moves unless the skid register is occupied
    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign push    = en && valid_pipe_reg[PIPE_DEPTH-1];
    assign pop     = out_valid_reg && m_ready;

    assign raw_in[0] = s_x_value;
    assign raw_in[1] = s_y_value;
    assign raw_in[2] = s_z_value;

    // Per-channel quotient unit and cube-root pipe
    for (genvar c = 0; c < 3; c++) begin : g_chan
        xlab_quot_unit u_quot (
            .aclk     (aclk),
            .en       (en),
            .raw      (raw_in[c]),
            .cc       (CHAN_CONST[c]),
            .quot_out (quot_w[c])
        );

        assign chain[c][0].q = quot_w[c];
        assign chain[c][0].y = '0;
        assign chain[c][0].s = '0;
        assign chain[c][0].d = D_W'(1);
        assign chain[c][0].r = '0;

        for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
            logic [U_W+ROOT_SHIFT-1:0] radicand;
            assign radicand = {chain[c][k].q.quot, {ROOT_SHIFT{1'b0}}};

            xlab_root_step u_step (
                .aclk      (aclk),
                .en        (en),
                .grp       (radicand[N_W-1-3*k -: 3]),
                .stage_in  (chain[c][k]),
                .stage_out (chain[c][k+1])
            );
        end

        assign f_in[c].q    = chain[c][ROOT_STAGES].q;
        assign f_in[c].root = chain[c][ROOT_STAGES].y;
    end

    xlab_lab_unit u_lab (
        .aclk   (aclk),
        .en     (en),
        .fx_in  (f_in[0]),
        .fy_in  (f_in[1]),
        .fz_in  (f_in[2]),
        .result (lab_result)
    );

    // Valid bits travel alongside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_pipe_reg <= '0;
        end else if (en) begin
            valid_pipe_reg <= {valid_pipe_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Output register with skid: drain the skid first, else take the pipe word
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_from_skid   = 1'b0;
        if (skid_valid_reg) begin
            if (pop) begin
                load_out        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= out_from_skid ? skid_reg : lab_result;
        end
        if (load_skid) begin
            skid_reg <= lab_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_lightness   = out_reg.lightness;
    assign m_red_green   = out_reg.red_green;
    assign m_yellow_blue = out_reg.yellow_blue;

endmodule

[design/xlab_port_checker.sv]
// Port-level checks for the converter, bound to the top level.
module xlab_port_checker
    import xlab_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic [RAW_W-1:0]           s_x_value,
    input logic [RAW_W-1:0]           s_y_value,
    input logic [RAW_W-1:0]           s_z_value,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [LIGHT_W-1:0]         m_lightness,
    input logic signed [CHROMA_W-1:0] m_red_green,
    input logic signed [CHROMA_W-1:0] m_yellow_blue
);

    // Reset empties the output side
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A stalled result word holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_lightness)
            && $stable(m_red_green) && $stable(m_yellow_blue))
        else $error("result word changed while stalled");

    // Input side only backs up behind a stalled result
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready dropped without an output stall");

    // Skid full implies a result is on offer
    a_busy_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no result word pending");

endmodule

bind xyz_to_cielab_converter_unit xlab_port_checker u_port_checker (.*);

[test/xyz_to_cielab_checker.sv]
// Scoreboard for the XYZ to L*a*b* converter: predicts each color word and checks the results.
`timescale 1ns / 100ps

module xyz_to_cielab_checker
    import xlab_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [RAW_W-1:0]           s_x_value,
    input  logic [RAW_W-1:0]           s_y_value,
    input  logic [RAW_W-1:0]           s_z_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [LIGHT_W-1:0]         m_lightness,
    input  logic signed [CHROMA_W-1:0] m_red_green,
    input  logic signed [CHROMA_W-1:0] m_yellow_blue,
    output int                         error_total,
    output int                         words_in_flight
);

    // D65 white in thousandths, knee in millionths, slope in thousandths
    localparam longint unsigned X_WHITE    = 64'd95047;
    localparam longint unsigned Y_WHITE    = 64'd100000;
    localparam longint unsigned Z_WHITE    = 64'd108883;
    localparam longint unsigned KNEE_MICRO = 64'd8856;
    localparam longint unsigned SLOPE      = 64'd7787;
    localparam int              CURVE_FRAC = 24;
    localparam int              RATIO_FRAC = 30;
    localparam int              CUBE_SHIFT = 42;
    localparam longint unsigned CURVE_BASE = ((64'd16 << CURVE_FRAC) + 64'd58) / 64'd116;

    result_t lab_q[$];

    // Floor of the cube root of ratio * 2^42, one bit per pass
    function automatic longint unsigned cube_root_floor(input longint unsigned ratio);
        logic [127:0] radicand;
        logic [127:0] root;
        logic [127:0] trial;
        radicand = 128'(ratio) << CUBE_SHIFT;
        root     = '0;
        for (int b = 26; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root[63:0];
    endfunction

    // f(t) with 24 fraction bits for one tristimulus channel
    function automatic longint lab_curve(input longint unsigned raw,
                                         input longint unsigned white);
        longint unsigned span;
        longint unsigned ratio;
        span = white << IN_FRAC_BITS;
        if (raw * 64'd1000000000 > KNEE_MICRO * span) begin
            ratio = ((raw * 64'd1000) << (RATIO_FRAC - IN_FRAC_BITS)) / white;
            return longint'(cube_root_floor(ratio));
        end
        return longint'(((raw * SLOPE) << CURVE_FRAC) / span + CURVE_BASE);
    endfunction

    // Round to the output format, halves away from zero
    function automatic longint round_to_output(input longint v);
        longint half;
        half = 64'sd1 <<< (CURVE_FRAC - OUT_FRAC_BITS - 1);
        if (v < 0) begin
            return -((-v + half) >>> (CURVE_FRAC - OUT_FRAC_BITS));
        end
        return (v + half) >>> (CURVE_FRAC - OUT_FRAC_BITS);
    endfunction

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic result_t predict_lab(input logic [RAW_W-1:0] x,
                                            input logic [RAW_W-1:0] y,
                                            input logic [RAW_W-1:0] z);
        longint  fx;
        longint  fy;
        longint  fz;
        longint  l_out;
        longint  a_out;
        longint  b_out;
        result_t lab;
        fx = lab_curve(64'(x), X_WHITE);
        fy = lab_curve(64'(y), Y_WHITE);
        fz = lab_curve(64'(z), Z_WHITE);
        l_out = round_to_output(64'sd116 * fy - (64'sd16 <<< CURVE_FRAC));
        a_out = round_to_output(64'sd500 * (fx - fy));
        b_out = round_to_output(64'sd200 * (fy - fz));
        l_out = clamp_range(l_out, 0, LIGHT_MAX);
        a_out = clamp_range(a_out, CHROMA_MIN, CHROMA_MAX);
        b_out = clamp_range(b_out, CHROMA_MIN, CHROMA_MAX);
        lab.lightness   = l_out[LIGHT_W-1:0];
        lab.red_green   = a_out[CHROMA_W-1:0];
        lab.yellow_blue = b_out[CHROMA_W-1:0];
        return lab;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        error_total++;
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    endtask

    // Queue a prediction per accepted color word, check each result word against the oldest
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            lab_q.delete();
            error_total     = 0;
            words_in_flight = 0;
        end else begin
            if (s_valid && s_ready) begin
                lab_q.push_back(predict_lab(s_x_value, s_y_value, s_z_value));
            end
            if (m_valid && m_ready) begin
                if (lab_q.size() == 0) begin
                    error_total++;
                    $display("%0t: unexpected result word, expected none, got %0d %0d %0d",
                             $time, m_lightness, m_red_green, m_yellow_blue);
                end else begin
                    want = lab_q.pop_front();
                    if (m_lightness !== want.lightness) begin
                        note_mismatch("lightness", want.lightness, m_lightness);
                    end
                    if (m_red_green !== want.red_green) begin
                        note_mismatch("red_green", want.red_green, m_red_green);
                    end
                    if (m_yellow_blue !== want.yellow_blue) begin
                        note_mismatch("yellow_blue", want.yellow_blue, m_yellow_blue);
                    end
                end
            end
            words_in_flight = lab_q.size();
        end
    end

endmodule

[test/xyz_to_cielab_converter_unit_test.sv]
// Top of the converter testbench: clock, reset, color word stimulus, result backpressure, verdict.
`timescale 1ns / 100ps

module xyz_to_cielab_converter_unit_test
    import xlab_pkg::*;
();

    // Raw codes at the linear/cube-root knee of each channel
    localparam int X_KNEE     = 430;
    localparam int Y_KNEE     = 453;
    localparam int Z_KNEE     = 493;
    localparam int PHASE_WORDS = 400;
    localparam int HOLD_CYCLES = 300;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [RAW_W-1:0]           s_x_value;
    logic [RAW_W-1:0]           s_y_value;
    logic [RAW_W-1:0]           s_z_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [LIGHT_W-1:0]         m_lightness;
    logic signed [CHROMA_W-1:0] m_red_green;
    logic signed [CHROMA_W-1:0] m_yellow_blue;

    int error_total;
    int words_in_flight;
    int send_idle_pct = 23;
    int recv_idle_pct = 87;
    bit hold_request  = 1'b0;

    xyz_to_cielab_converter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_x_value     (s_x_value),
        .s_y_value     (s_y_value),
        .s_z_value     (s_z_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_lightness   (m_lightness),
        .m_red_green   (m_red_green),
        .m_yellow_blue (m_yellow_blue)
    );

    xyz_to_cielab_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_x_value       (s_x_value),
        .s_y_value       (s_y_value),
        .s_z_value       (s_z_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_lightness     (m_lightness),
        .m_red_green     (m_red_green),
        .m_yellow_blue   (m_yellow_blue),
        .error_total     (error_total),
        .words_in_flight (words_in_flight)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Idle at random, then offer one color word and hold it until accepted
    task automatic send_color(input logic [RAW_W-1:0] x,
                              input logic [RAW_W-1:0] y,
                              input logic [RAW_W-1:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_x_value <= x;
        s_y_value <= y;
        s_z_value <= z;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mix full-range codes, low codes spanning the linear region, the knee and mid-range colors
    function automatic logic [RAW_W-1:0] random_tristimulus(input int knee);
        case ($urandom_range(3))
            0:       return RAW_W'($urandom_range(65535));
            1:       return RAW_W'($urandom_range(1023));
            2:       return RAW_W'(knee - 4 + $urandom_range(8));
            default: return RAW_W'($urandom_range(60000, 2000));
        endcase
    endfunction

    task automatic send_random_phase;
        repeat (PHASE_WORDS) begin
            send_color(random_tristimulus(X_KNEE), random_tristimulus(Y_KNEE),
                       random_tristimulus(Z_KNEE));
        end
    endtask

    // Drop valid and wait for every predicted word to come back
    task automatic drain_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (words_in_flight == 0);
        @(posedge aclk);
    endtask

    // Result side: random backpressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_x_value = '0;
        s_y_value = '0;
        s_z_value = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words: extremes, white point, knees, dominant channels
        send_color(16'd0, 16'd0, 16'd0);
        send_color(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_color(16'd48664, 16'd51200, 16'd55748);
        send_color(16'(X_KNEE - 1), 16'(Y_KNEE - 1), 16'(Z_KNEE - 1));
        send_color(16'(X_KNEE), 16'(Y_KNEE), 16'(Z_KNEE));
        send_color(16'(X_KNEE + 1), 16'(Y_KNEE + 1), 16'(Z_KNEE + 1));
        send_color(16'(X_KNEE + 2), 16'(Y_KNEE + 2), 16'(Z_KNEE + 2));
        send_color(16'hFFFF, 16'd0, 16'd0);
        send_color(16'd0, 16'hFFFF, 16'd0);
        send_color(16'd0, 16'd0, 16'hFFFF);
        send_color(16'd0, 16'hFFFF, 16'hFFFF);
        send_color(16'hFFFF, 16'hFFFF, 16'd0);
        send_color(16'hFFFF, 16'd0, 16'hFFFF);
        send_color(16'd1, 16'd1, 16'd1);
        send_color(16'hAAAA, 16'h5555, 16'hAAAA);
        send_color(16'h5555, 16'hAAAA, 16'h5555);
        send_color(16'd25600, 16'd25600, 16'd25600);
        send_color(16'h8000, 16'h7FFF, 16'h0001);

        send_random_phase();
        drain_results();

        send_idle_pct = 87;
        recv_idle_pct = 23;
        send_random_phase();

        // Stall the result side for a long stretch while words keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        send_random_phase();

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (words_in_flight == 0);
        repeat (60) @(posedge aclk);
        if (error_total == 0 && words_in_flight == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
